### rtl/csalu_pkg.sv
// Package for the complex sample ALU: action codes, register indices, default widths and the
// control group that travels with each request down the pipeline.
// No dependencies.
package csalu_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 12;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_SCALE = 3'd4,
        ACT_BIAS  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REG_SCALE_RE = 2'd0,
        REG_SCALE_IM = 2'd1,
        REG_BIAS_RE  = 2'd2,
        REG_BIAS_IM  = 2'd3
    } reg_index_t;

    // Control flags that ride beside each request through the divider cells.
    typedef struct packed {
        logic is_div;
        logic zdiv;
        logic sat;
        logic last;
        logic neg_re;
        logic neg_im;
    } ctl_t;

endpackage

### rtl/complex_sample_alu_top.sv
// Top level of the complex sample ALU: front end, divider cell chain and
// output register with skid stage. Depends on csalu_pkg, csalu_front, csalu_div_cell.
//
// Usage:
//   Input channel s_*: one request carries an action code, operands a and b
//   (signed fixed point) and a last marker. Result channel m_*: one result
//   per request, in order: r_re/r_im clamped, zero_divisor, saturated and
//   last_out. Config port: cfg_we with cfg_index/cfg_wdata writes scale_re,
//   scale_im, bias_re, bias_im; write only while idle.
//   Throughput: one request per cycle, sustained while m_ready stays high.
//   Every action walks the same pipeline: input register, product stage, sum
//   stage, then one divider cell per quotient bit (2*SAMPLE_WIDTH+FRACTION_BITS
//   cells), then the output register.
//   Stall: when the receiver holds m_ready low, one more result parks in the
//   skid stage; s_ready then drops and the whole pipeline holds until the
//   skid stage moves into the output register. s_ready is a register output.
//   Reset: synchronous active low; clears all valid bits, empties the
//   pipeline and loads scale 1.0+0i and bias 0+0i.
module complex_sample_alu_top #(
    parameter int SAMPLE_WIDTH  = csalu_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = csalu_pkg::FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_action,
    input  logic signed [SAMPLE_WIDTH-1:0] s_a_re,
    input  logic signed [SAMPLE_WIDTH-1:0] s_a_im,
    input  logic signed [SAMPLE_WIDTH-1:0] s_b_re,
    input  logic signed [SAMPLE_WIDTH-1:0] s_b_im,
    input  logic                          s_last_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_r_re,
    output logic signed [SAMPLE_WIDTH-1:0] m_r_im,
    output logic                          m_zero_divisor,
    output logic                          m_saturated,
    output logic                          m_last_out,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]       cfg_wdata
);
    import csalu_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int NQ = 2*SAMPLE_WIDTH + FRACTION_BITS;
    localparam logic [NQ-1:0] HALF = NQ'(1) << (W-1);

    // Pipeline advances whenever the skid stage is empty.
    logic adv;
    logic skid_valid_reg;
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    // Chain taps: index 0 is the front end, index NQ the last cell.
    logic           v_c     [0:NQ];
    ctl_t           ctl_c   [0:NQ];
    logic [W-1:0]   rre_c   [0:NQ];
    logic [W-1:0]   rim_c   [0:NQ];
    logic [2*W-1:0] den_c   [0:NQ];
    logic [2*W-1:0] remre_c [0:NQ];
    logic [2*W-1:0] remim_c [0:NQ];
    logic [NQ-1:0]  nre_c   [0:NQ];
    logic [NQ-1:0]  nim_c   [0:NQ];
    logic [2*W-1:0] mag_re, mag_im;

    csalu_front #(.W(W), .F(FRACTION_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .s_valid    (s_valid),
        .s_action   (s_action),
        .s_a_re     (s_a_re),
        .s_a_im     (s_a_im),
        .s_b_re     (s_b_re),
        .s_b_im     (s_b_im),
        .s_last_in  (s_last_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .v_out      (v_c[0]),
        .ctl_out    (ctl_c[0]),
        .r_re_out   (rre_c[0]),
        .r_im_out   (rim_c[0]),
        .mag_re_out (mag_re),
        .mag_im_out (mag_im),
        .den_out    (den_c[0])
    );

    // Seed the divider: magnitude shifted up by the fraction bits, empty remainder.
    assign remre_c[0] = '0;
    assign remim_c[0] = '0;
    assign nre_c[0]   = NQ'(mag_re) << FRACTION_BITS;
    assign nim_c[0]   = NQ'(mag_im) << FRACTION_BITS;

    for (genvar k = 0; k < NQ; k++) begin : g_cell
        csalu_div_cell #(.W(W), .NQ(NQ)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (adv),
            .v_in       (v_c[k]),
            .ctl_in     (ctl_c[k]),
            .r_re_in    (rre_c[k]),
            .r_im_in    (rim_c[k]),
            .den_in     (den_c[k]),
            .rem_re_in  (remre_c[k]),
            .rem_im_in  (remim_c[k]),
            .n_re_in    (nre_c[k]),
            .n_im_in    (nim_c[k]),
            .v_out      (v_c[k+1]),
            .ctl_out    (ctl_c[k+1]),
            .r_re_out   (rre_c[k+1]),
            .r_im_out   (rim_c[k+1]),
            .den_out    (den_c[k+1]),
            .rem_re_out (remre_c[k+1]),
            .rem_im_out (remim_c[k+1]),
            .n_re_out   (nre_c[k+1]),
            .n_im_out   (nim_c[k+1])
        );
    end

    // Apply the sign to a quotient magnitude and clamp to the sample range.
    function automatic logic [W:0] sign_clamp(input logic [NQ-1:0] q, input logic neg);
        logic [NQ-1:0] nq;
        logic [W:0]    res;
        nq = -q;
        if (neg) begin
            if (q > HALF) begin
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                res = {1'b0, nq[W-1:0]};
            end
        end else begin
            if (q >= HALF) begin
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                res = {1'b0, q[W-1:0]};
            end
        end
        return res;
    endfunction

    typedef struct packed {
        logic [W-1:0] r_re;
        logic [W-1:0] r_im;
        logic         zdiv;
        logic         sat;
        logic         last;
    } res_t;

    logic [W:0] fq_re, fq_im;
    res_t       fin;

    always_comb begin
        fq_re = sign_clamp(nre_c[NQ], ctl_c[NQ].neg_re);
        fq_im = sign_clamp(nim_c[NQ], ctl_c[NQ].neg_im);
        fin.last = ctl_c[NQ].last;
        fin.zdiv = ctl_c[NQ].zdiv;
        if (ctl_c[NQ].zdiv) begin
            fin.r_re = '0;
            fin.r_im = '0;
            fin.sat  = 1'b0;
        end else if (ctl_c[NQ].is_div) begin
            fin.r_re = fq_re[W-1:0];
            fin.r_im = fq_im[W-1:0];
            fin.sat  = fq_re[W] | fq_im[W];
        end else begin
            fin.r_re = rre_c[NQ];
            fin.r_im = rim_c[NQ];
            fin.sat  = ctl_c[NQ].sat;
        end
    end

    // Output register plus skid stage.
    logic m_valid_reg;
    res_t out_reg, skid_reg;
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            // Drain the skid first; otherwise take the chain's last cell.
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= v_c[NQ];
            end
        end else if (adv && v_c[NQ]) begin
            // Receiver stalled: park the arriving request.
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end
        if (!out_free && adv) begin
            skid_reg <= fin;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_r_re         = $signed(out_reg.r_re);
    assign m_r_im         = $signed(out_reg.r_im);
    assign m_zero_divisor = out_reg.zdiv;
    assign m_saturated    = out_reg.sat;
    assign m_last_out     = out_reg.last;

    // The skid stage only ever holds a request behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid stage full while output register empty");

    // Backpressure on input only follows a stalled result.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready dropped without a stalled result");

    // A zero divisor forces a zero result with no clamp flag.
    a_zdiv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_divisor) |-> (!m_saturated && m_r_re == '0 && m_r_im == '0))
        else $error("zero divisor result not forced to zero");

endmodule

### rtl/csalu_front.sv
// Front end of the complex sample ALU: input register, configuration
// registers, product stage and the sum/clamp stage that feeds the divider.
// Depends on csalu_pkg.
module csalu_front #(
    parameter int W = csalu_pkg::SAMPLE_WIDTH_DEF,
    parameter int F = csalu_pkg::FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  s_valid,
    input  logic [2:0]            s_action,
    input  logic signed [W-1:0]   s_a_re,
    input  logic signed [W-1:0]   s_a_im,
    input  logic signed [W-1:0]   s_b_re,
    input  logic signed [W-1:0]   s_b_im,
    input  logic                  s_last_in,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [W-1:0]          cfg_wdata,
    output logic                  v_out,
    output csalu_pkg::ctl_t       ctl_out,
    output logic [W-1:0]          r_re_out,
    output logic [W-1:0]          r_im_out,
    output logic [2*W-1:0]        mag_re_out,
    output logic [2*W-1:0]        mag_im_out,
    output logic [2*W-1:0]        den_out
);
    import csalu_pkg::*;

    localparam logic signed [2*W:0] MAXV =
        $signed(((2*W+1)'(1) << (W-1)) - (2*W+1)'(1));
    localparam logic signed [2*W:0] MINV = ~MAXV;
    localparam logic [W-1:0] SCALE_ONE =
        (F <= W-2) ? (W'(1) << F) : {1'b0, {(W-1){1'b1}}};

    function automatic logic [W:0] clamp_w(input logic signed [2*W:0] x);
        logic [W:0] res;
        if (x > MAXV) begin
            res = {1'b1, MAXV[W-1:0]};
        end else if (x < MINV) begin
            res = {1'b1, MINV[W-1:0]};
        end else begin
            res = {1'b0, x[W-1:0]};
        end
        return res;
    endfunction

    logic [W-1:0] scale_re_reg, scale_im_reg, bias_re_reg, bias_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_re_reg <= SCALE_ONE;
            scale_im_reg <= '0;
            bias_re_reg  <= '0;
            bias_im_reg  <= '0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_SCALE_RE: scale_re_reg <= cfg_wdata;
                REG_SCALE_IM: scale_im_reg <= cfg_wdata;
                REG_BIAS_RE:  bias_re_reg  <= cfg_wdata;
                REG_BIAS_IM:  bias_im_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 0: input register.
    logic                v0_reg, last0_reg;
    action_t             op0_reg;
    logic signed [W-1:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op0_reg   <= action_t'(s_action);
            ar0_reg   <= s_a_re;
            ai0_reg   <= s_a_im;
            br0_reg   <= s_b_re;
            bi0_reg   <= s_b_im;
            last0_reg <= s_last_in;
        end
    end

    // Stage 1: pick the second operand, form all products.
    logic signed [W-1:0] bsel_re, bsel_im;

    always_comb begin
        case (op0_reg)
            ACT_SCALE: begin
                bsel_re = $signed(scale_re_reg);
                bsel_im = $signed(scale_im_reg);
            end
            ACT_BIAS: begin
                bsel_re = $signed(bias_re_reg);
                bsel_im = $signed(bias_im_reg);
            end
            default: begin
                bsel_re = br0_reg;
                bsel_im = bi0_reg;
            end
        endcase
    end

    logic                  v1_reg, last1_reg;
    action_t               op1_reg;
    logic signed [W-1:0]   ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [2*W-1:0] prr_reg, pii_reg, pri_reg, pir_reg, qrr_reg, qii_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg   <= op0_reg;
            last1_reg <= last0_reg;
            ar1_reg   <= ar0_reg;
            ai1_reg   <= ai0_reg;
            br1_reg   <= bsel_re;
            bi1_reg   <= bsel_im;
            prr_reg   <= ar0_reg * bsel_re;
            pii_reg   <= ai0_reg * bsel_im;
            pri_reg   <= ar0_reg * bsel_im;
            pir_reg   <= ai0_reg * bsel_re;
            qrr_reg   <= bsel_re * bsel_re;
            qii_reg   <= bsel_im * bsel_im;
        end
    end

    // Stage 2: sums, clamp for the direct actions, divider operands.
    logic signed [2*W:0] ext_prr, ext_pii, ext_pri, ext_pir;
    logic signed [2*W:0] x_re, x_im, num_re, num_im, neg_num_re, neg_num_im;
    logic [W:0]          cl_re, cl_im;
    ctl_t                ctl_next;

    always_comb begin
        ext_prr = {prr_reg[2*W-1], prr_reg};
        ext_pii = {pii_reg[2*W-1], pii_reg};
        ext_pri = {pri_reg[2*W-1], pri_reg};
        ext_pir = {pir_reg[2*W-1], pir_reg};
        num_re  = ext_prr + ext_pii;
        num_im  = ext_pir - ext_pri;
        neg_num_re = -num_re;
        neg_num_im = -num_im;
        case (op1_reg)
            ACT_ADD, ACT_BIAS: begin
                x_re = (2*W+1)'(ar1_reg) + (2*W+1)'(br1_reg);
                x_im = (2*W+1)'(ai1_reg) + (2*W+1)'(bi1_reg);
            end
            ACT_SUB: begin
                x_re = (2*W+1)'(ar1_reg) - (2*W+1)'(br1_reg);
                x_im = (2*W+1)'(ai1_reg) - (2*W+1)'(bi1_reg);
            end
            ACT_MUL, ACT_SCALE: begin
                x_re = (ext_prr - ext_pii) >>> F;
                x_im = (ext_pri + ext_pir) >>> F;
            end
            default: begin
                x_re = (2*W+1)'(ar1_reg);
                x_im = (2*W+1)'(ai1_reg);
            end
        endcase
        cl_re = clamp_w(x_re);
        cl_im = clamp_w(x_im);
        ctl_next.is_div = (op1_reg == ACT_DIV);
        ctl_next.zdiv   = (op1_reg == ACT_DIV) && (br1_reg == '0) && (bi1_reg == '0);
        ctl_next.sat    = cl_re[W] | cl_im[W];
        ctl_next.last   = last1_reg;
        ctl_next.neg_re = num_re[2*W];
        ctl_next.neg_im = num_im[2*W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out <= 1'b0;
        end else if (adv) begin
            v_out <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_out    <= ctl_next;
            r_re_out   <= cl_re[W-1:0];
            r_im_out   <= cl_im[W-1:0];
            mag_re_out <= num_re[2*W] ? neg_num_re[2*W-1:0] : num_re[2*W-1:0];
            mag_im_out <= num_im[2*W] ? neg_num_im[2*W-1:0] : num_im[2*W-1:0];
            den_out    <= qrr_reg[2*W-1:0] + qii_reg[2*W-1:0];
        end
    end

endmodule

### rtl/csalu_div_cell.sv
// One restoring-division cell of the complex sample ALU: develops one
// quotient bit for the real and the imaginary lane. Depends on csalu_pkg.
module csalu_div_cell #(
    parameter int W  = csalu_pkg::SAMPLE_WIDTH_DEF,
    parameter int NQ = 2*csalu_pkg::SAMPLE_WIDTH_DEF + csalu_pkg::FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              v_in,
    input  csalu_pkg::ctl_t   ctl_in,
    input  logic [W-1:0]      r_re_in,
    input  logic [W-1:0]      r_im_in,
    input  logic [2*W-1:0]    den_in,
    input  logic [2*W-1:0]    rem_re_in,
    input  logic [2*W-1:0]    rem_im_in,
    input  logic [NQ-1:0]     n_re_in,
    input  logic [NQ-1:0]     n_im_in,
    output logic              v_out,
    output csalu_pkg::ctl_t   ctl_out,
    output logic [W-1:0]      r_re_out,
    output logic [W-1:0]      r_im_out,
    output logic [2*W-1:0]    den_out,
    output logic [2*W-1:0]    rem_re_out,
    output logic [2*W-1:0]    rem_im_out,
    output logic [NQ-1:0]     n_re_out,
    output logic [NQ-1:0]     n_im_out
);
    import csalu_pkg::*;

    logic [2*W:0] sh_re, sh_im, tr_re, tr_im;

    always_comb begin
        sh_re = {rem_re_in, n_re_in[NQ-1]};
        sh_im = {rem_im_in, n_im_in[NQ-1]};
        tr_re = sh_re - {1'b0, den_in};
        tr_im = sh_im - {1'b0, den_in};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out <= 1'b0;
        end else if (en) begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_out    <= ctl_in;
            r_re_out   <= r_re_in;
            r_im_out   <= r_im_in;
            den_out    <= den_in;
            rem_re_out <= tr_re[2*W] ? sh_re[2*W-1:0] : tr_re[2*W-1:0];
            rem_im_out <= tr_im[2*W] ? sh_im[2*W-1:0] : tr_im[2*W-1:0];
            n_re_out   <= {n_re_in[NQ-2:0], ~tr_re[2*W]};
            n_im_out   <= {n_im_in[NQ-2:0], ~tr_im[2*W]};
        end
    end

endmodule
